### rtl/core/trin_pkg.sv
`default_nettype none

package trin_pkg;

    // Internal arithmetic width: aligned ends can exceed 32 bits before wrap.
    localparam int DW = 34;

    typedef struct packed {
        logic          go;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } div_rsp_t;

    // Reduction intervals in seconds; unused slots are zero and never qualify.
    function automatic logic [16:0] reduction_iv(input logic [5:0] slot);
        logic [16:0] r;
        case (slot)
            6'd0:    r = 17'd10;
            6'd1:    r = 17'd20;
            6'd2:    r = 17'd30;
            6'd3:    r = 17'd60;
            6'd4:    r = 17'd120;
            6'd5:    r = 17'd300;
            6'd6:    r = 17'd600;
            6'd7:    r = 17'd900;
            6'd8:    r = 17'd1200;
            6'd9:    r = 17'd1800;
            6'd10:   r = 17'd3600;
            6'd11:   r = 17'd7200;
            6'd12:   r = 17'd10800;
            6'd13:   r = 17'd14400;
            6'd14:   r = 17'd21600;
            6'd15:   r = 17'd28800;
            6'd16:   r = 17'd43200;
            6'd17:   r = 17'd86400;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/time_range_interval_normalizer.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: range_start, range_end, native_interval,
//                                  sample_limit
// m_*      out  m_tvalid/m_tready  tdata: aligned_start, aligned_end, chosen_interval;
//                                  tuser: span_error
//
// Divisions: a single-bucket zero span needs none. Otherwise the shared radix-2
// divider does three divisions for plain alignment (two in single-bucket mode),
// up to two per reduction table entry, one for the fallback and two more to
// realign.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// Stalls: a finished item waits in the output register while the next item
// is taken; the sequencer holds in its last step until that register is free.
module time_range_interval_normalizer
    import trin_pkg::*;
#(
    parameter int TABLE_ENTRIES = 18
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,  // range_start, range_end, native_interval,
                                        // sample_limit, 4 zero bits
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,  // aligned_start, aligned_end, chosen_interval
    output logic              m_tuser   // span_error
);

    localparam int IW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVW, S_AL_S, S_AL_E, S_SPAN, S_WALK,
        S_MOD, S_CNT, S_FALL, S_FINISH
    } state_t;

    state_t        state_reg;
    state_t        ret_reg;
    logic [DW-1:0] st_reg;
    logic [DW-1:0] en_reg;
    logic [DW-1:0] iv_reg;
    logic [DW-1:0] span_reg;
    logic [16:0]   tgt_reg;
    logic [19:0]   lim_reg;
    logic [IW-1:0] idx_reg;
    logic          single_reg;
    logic          pass_reg;
    logic          err_reg;
    logic          div_go_reg;
    logic [DW-1:0] div_a_reg;
    logic [DW-1:0] div_b_reg;
    logic          m_tvalid_reg;
    logic [95:0]   m_tdata_reg;
    logic          m_tuser_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [31:0]   in_start;
    logic [31:0]   in_end;
    logic [31:0]   in_native;
    logic [19:0]   in_limit;
    logic [DW-1:0] in_s;
    logic [DW-1:0] in_e;
    logic [DW-1:0] in_iv;
    logic [DW-1:0] al_end;
    logic [16:0]   tbl_r;
    logic [DW-1:0] tbl_w;

    assign in_start  = s_tdata[31:0];
    assign in_end    = s_tdata[63:32];
    assign in_native = s_tdata[95:64];
    assign in_limit  = s_tdata[115:96];

    // Clamp an end before the start to the start.
    assign in_s  = {2'b00, in_start};
    assign in_e  = (in_end < in_start) ? in_s : {2'b00, in_end};
    assign in_iv = (in_native == 32'd0) ? DW'(10) : {2'b00, in_native};

    // Round up: add one interval less the remainder when off the grid.
    assign al_end = (div_rsp.rem == '0) ? en_reg : en_reg - div_rsp.rem + iv_reg;

    assign tbl_r = reduction_iv(6'(idx_reg));
    assign tbl_w = DW'(tbl_r);

    assign div_req.go       = div_go_reg;
    assign div_req.dividend = div_a_reg;
    assign div_req.divisor  = div_b_reg;

    trin_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            div_go_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Drop the output item once taken, unless a new one is loaded now.
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        lim_reg    <= in_limit;
                        single_reg <= (in_limit == 20'd1);
                        pass_reg   <= 1'b0;
                        st_reg     <= in_s;
                        if (in_limit == 20'd1 && in_e == in_s)
                        begin
                            // Zero span in single-bucket mode: pass inputs through.
                            en_reg    <= {2'b00, in_end};
                            iv_reg    <= {2'b00, in_native};
                            err_reg   <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            en_reg     <= in_e;
                            err_reg    <= 1'b0;
                            iv_reg     <= (in_limit == 20'd1) ? in_e - in_s : in_iv;
                            div_a_reg  <= in_s;
                            div_b_reg  <= (in_limit == 20'd1) ? in_e - in_s : in_iv;
                            div_go_reg <= 1'b1;
                            ret_reg    <= S_AL_S;
                            state_reg  <= S_DIVW;
                        end
                    end
                end
                S_DIVW:
                begin
                    // The launch pulse lasts one cycle.
                    div_go_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_AL_S:
                begin
                    st_reg     <= st_reg - div_rsp.rem;
                    div_a_reg  <= en_reg;
                    div_b_reg  <= iv_reg;
                    div_go_reg <= 1'b1;
                    ret_reg    <= S_AL_E;
                    state_reg  <= S_DIVW;
                end
                S_AL_E:
                begin
                    en_reg <= al_end;
                    if (single_reg)
                    begin
                        iv_reg    <= al_end - st_reg;
                        state_reg <= S_FINISH;
                    end
                    else if (pass_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        span_reg   <= al_end - st_reg;
                        div_a_reg  <= al_end - st_reg;
                        div_b_reg  <= iv_reg;
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_SPAN;
                        state_reg  <= S_DIVW;
                    end
                end
                S_SPAN:
                begin
                    if (lim_reg != 20'd0 && div_rsp.quot > DW'(lim_reg))
                    begin
                        idx_reg   <= '0;
                        tgt_reg   <= '0;
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_WALK:
                begin
                    if (idx_reg == IW'(TABLE_ENTRIES))
                    begin
                        if (tgt_reg == '0)
                        begin
                            div_a_reg  <= span_reg;
                            div_b_reg  <= DW'(lim_reg);
                            div_go_reg <= 1'b1;
                            ret_reg    <= S_FALL;
                            state_reg  <= S_DIVW;
                        end
                        else
                        begin
                            // Take the last qualifying entry.
                            iv_reg     <= DW'(tgt_reg);
                            pass_reg   <= 1'b1;
                            div_a_reg  <= st_reg;
                            div_b_reg  <= DW'(tgt_reg);
                            div_go_reg <= 1'b1;
                            ret_reg    <= S_AL_S;
                            state_reg  <= S_DIVW;
                        end
                    end
                    else if (tbl_w <= iv_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        div_a_reg  <= tbl_w;
                        div_b_reg  <= iv_reg;
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_MOD;
                        state_reg  <= S_DIVW;
                    end
                end
                S_MOD:
                begin
                    if (div_rsp.rem != '0)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        tgt_reg    <= tbl_r;
                        div_a_reg  <= span_reg;
                        div_b_reg  <= tbl_w;
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_CNT;
                        state_reg  <= S_DIVW;
                    end
                end
                S_CNT:
                begin
                    if (div_rsp.quot <= DW'(lim_reg))
                    begin
                        iv_reg     <= tbl_w;
                        pass_reg   <= 1'b1;
                        div_a_reg  <= st_reg;
                        div_b_reg  <= tbl_w;
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_AL_S;
                        state_reg  <= S_DIVW;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_FALL:
                begin
                    // Keep the first alignment when span/limit is under twice the interval.
                    if ({1'b0, div_rsp.quot} < {iv_reg, 1'b0})
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        iv_reg     <= div_rsp.quot;
                        pass_reg   <= 1'b1;
                        div_a_reg  <= st_reg;
                        div_b_reg  <= div_rsp.quot;
                        div_go_reg <= 1'b1;
                        ret_reg    <= S_AL_S;
                        state_reg  <= S_DIVW;
                    end
                end
                S_FINISH:
                begin
                    // Hold until the output register is free.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {iv_reg[31:0], en_reg[31:0], st_reg[31:0]};
                        m_tuser_reg  <= err_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The divider finishes only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIVW)
        else $error("divider finished outside wait step");

    // No item is taken while a division is still running.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_rsp.busy)
        else $error("divider busy while idle");

    // Every launch starts the divider in the next cycle.
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        div_go_reg |=> div_rsp.busy)
        else $error("division launch lost");

endmodule

`default_nettype wire

### rtl/core/trin_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module trin_div
    import trin_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DW-1:0]          quo_reg;
    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          dvs_reg;
    logic [$clog2(DW+1)-1:0] cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [DW:0]   shifted;
    logic          ge;
    logic [DW-1:0] rem_next;

    assign shifted  = {rem_reg, quo_reg[DW-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign rem_next = ge ? DW'(shifted - {1'b0, dvs_reg}) : shifted[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= ($clog2(DW+1))'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ($clog2(DW+1))'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

### tb/time_range_interval_normalizer_checker.sv
module time_range_interval_normalizer_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic [31:0] aligned_start;
        logic [31:0] aligned_end;
        logic [31:0] chosen_interval;
        logic        span_error;
    } window_t;

    window_t windows_due[$];

    function automatic logic [63:0] floor_to(input logic [63:0] t, input logic [63:0] iv);
        return t - (t % iv);
    endfunction

    function automatic logic [63:0] ceil_to(input logic [63:0] t, input logic [63:0] iv);
        logic [63:0] over;
        over = t % iv;
        return (over != 0) ? t - over + iv : t;
    endfunction

    function automatic window_t normalize_window(input logic [119:0] d);
        logic [63:0] t0, t1, nat, lim, iv, span, target, r;
        logic        err;
        window_t     w;
        t0  = {32'd0, d[31:0]};
        t1  = {32'd0, d[63:32]};
        nat = {32'd0, d[95:64]};
        lim = {44'd0, d[115:96]};
        err = 1'b0;
        if (t1 < t0)
            t1 = t0;
        if (lim == 1) begin
            iv = t1 - t0;
            if (iv == 0) begin
                // zero span for a single bucket: hand the query back untouched
                t0  = {32'd0, d[31:0]};
                t1  = {32'd0, d[63:32]};
                iv  = nat;
                err = 1'b1;
            end
            else begin
                t0 = floor_to(t0, iv);
                t1 = ceil_to(t1, iv);
                iv = t1 - t0;
            end
        end
        else begin
            iv = (nat != 0) ? nat : 64'd10;
            t0 = floor_to(t0, iv);
            t1 = ceil_to(t1, iv);
            span = t1 - t0;
            if (lim != 0 && span / iv > lim) begin
                target = 0;
                for (int i = 0; i < 18; i++) begin
                    r = {47'd0, trin_pkg::reduction_iv(6'(i))};
                    if (r <= iv || (r % iv) != 0)
                        continue;
                    target = r;
                    if (span / r <= lim)
                        break;
                end
                if (target == 0) begin
                    target = span / lim;
                    if (target < iv * 2)
                        target = 0;
                end
                if (target != 0) begin
                    iv = target;
                    t0 = floor_to(t0, iv);
                    t1 = ceil_to(t1, iv);
                end
            end
        end
        w.aligned_start   = t0[31:0];
        w.aligned_end     = t1[31:0];
        w.chosen_interval = iv[31:0];
        w.span_error      = err;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_t want;
        if (!rst_n) begin
            windows_due.delete();
            fail_count = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                windows_due.insert(windows_due.size(), normalize_window(s_tdata));
            if (m_tvalid && m_tready) begin
                if (windows_due.size() == 0) begin
                    $error("unexpected result item: %h / %b", m_tdata, m_tuser);
                    fail_count++;
                end
                else begin
                    want = windows_due.pop_front();
                    if (m_tdata[31:0] !== want.aligned_start) begin
                        $error("aligned_start: expected %0d, got %0d",
                               want.aligned_start, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== want.aligned_end) begin
                        $error("aligned_end: expected %0d, got %0d",
                               want.aligned_end, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== want.chosen_interval) begin
                        $error("chosen_interval: expected %0d, got %0d",
                               want.chosen_interval, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tuser !== want.span_error) begin
                        $error("span_error: expected %0d, got %0d",
                               want.span_error, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = windows_due.size();
    end

endmodule

### tb/tb_time_range_interval_normalizer.sv
module tb_time_range_interval_normalizer;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending_count;

    // idle percentages for each side, switched per phase
    int tx_idle_pct;
    int rx_idle_pct;
    // cycles the receiver still has to hold off
    int rx_hold_cycles;

    time_range_interval_normalizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // range_start, range_end, native_interval, sample_limit
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // aligned_start, aligned_end, chosen_interval
        .m_tuser  (m_tuser)    // span_error
    );

    time_range_interval_normalizer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit: far above the slowest legal run.
    initial
    begin
        #400_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: stall at random, or hold off entirely while a long hold is pending.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                m_tready = 1'b0;
                rx_hold_cycles--;
            end
            else
                m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Present one query and hold it until accepted. Inputs change at the falling edge,
    // and s_tready seen there is what the next rising edge will see.
    task automatic offer_query(input logic [31:0] t0, input logic [31:0] t1,
                               input logic [31:0] nat, input logic [19:0] lim);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tdata  = {4'd0, lim, nat, t1, t0};
        s_tvalid = 1'b1;
        while (!s_tready)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Random query: mostly well-formed windows that push into the reduction walk.
    task automatic offer_random_query();
        logic [31:0] t0, t1, nat, span;
        logic [19:0] lim;
        case ($urandom_range(0, 5))
            0:       nat = 32'd0;
            1:       nat = 32'd10;
            2:       nat = {$urandom_range(1, 12)} * 32'd5;
            3:       nat = $urandom_range(1, 100);
            4:       nat = $urandom_range(1, 100000);
            default: nat = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       span = $urandom_range(0, 1000);
            1:       span = $urandom_range(0, 100000);
            2:       span = $urandom_range(0, 10_000_000);
            3:       span = $urandom;
            default: span = 32'd0;
        endcase
        case ($urandom_range(0, 5))
            0:       lim = 20'd0;
            1:       lim = 20'd1;
            2:       lim = 20'($urandom_range(2, 20));
            3:       lim = 20'($urandom_range(2, 2000));
            default: lim = 20'($urandom);
        endcase
        t0 = $urandom;
        t1 = t0 + span;
        // occasionally end before start or wrapped past the top
        if ($urandom_range(0, 9) == 0)
            t1 = $urandom;
        offer_query(t0, t1, nat, lim);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        rx_hold_cycles = 0;
        tx_idle_pct    = 33;
        rx_idle_pct    = 71;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, zero interval, single bucket, zero span,
        // end before start, table walk, fallback, fallback refused, wrap at the top.
        offer_query(32'd0, 32'd0, 32'd0, 20'd0);
        offer_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
        offer_query(32'd1005, 32'd2017, 32'd0, 20'd0);
        offer_query(32'd1234, 32'd1234, 32'd60, 20'd1);
        offer_query(32'd5000, 32'd100, 32'd7, 20'd1);
        offer_query(32'd5000, 32'd100, 32'd7, 20'd3);
        offer_query(32'd123, 32'd987_654, 32'd0, 20'd1);
        offer_query(32'd100, 32'd100_000, 32'd10, 20'd5);
        offer_query(32'd100, 32'd100_000, 32'd10, 20'd500);
        offer_query(32'd0, 32'd100_000_000, 32'd10, 20'd2);
        offer_query(32'd3, 32'd7_000_000, 32'd7, 20'd3);
        offer_query(32'd3, 32'd100, 32'd7, 20'd9);
        offer_query(32'd0, 32'hFFFF_FFF0, 32'd1000, 20'd0);
        offer_query(32'h8000_0000, 32'hFFFF_FFFF, 32'd86400, 20'd2);
        offer_query(32'h8000_0001, 32'hFFFF_FFFF, 32'd0, 20'd1);
        offer_query(32'd0, 32'hFFFF_FFFF, 32'd1, 20'hF_FFFF);
        offer_query(32'd59, 32'd1_000_061, 32'd60, 20'd2);
        offer_query(32'd1, 32'd2, 32'hFFFF_FFFF, 20'd2);

        for (int n = 0; n < 540; n++)
        begin
            if (n == 180) begin
                tx_idle_pct = 71;
                rx_idle_pct = 33;
            end
            else if (n == 360) begin
                tx_idle_pct    = 0;
                rx_idle_pct    = 0;
                // long receiver hold so the block backs up and drops s_tready
                rx_hold_cycles = 5000;
            end
            offer_random_query();
        end
        s_tvalid = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/core/trin_pkg.sv
rtl/core/trin_div.sv
rtl/core/time_range_interval_normalizer.sv
tb/time_range_interval_normalizer_checker.sv
tb/tb_time_range_interval_normalizer.sv
